// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the taper weighting top level.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define BTDW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define BTDW_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BTDW_ASSERT(lbl, clk, rst_n, prop, msg)
`define BTDW_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/btdw_pkg.sv =====
// ---------------------------------------------------------------------------
// Taper weighting package
// Widths, fixed-point constants and series tables of the taper datapath.
// ---------------------------------------------------------------------------
package btdw_pkg;

    localparam int unsigned DEG_W            = 12;
    localparam int unsigned COEF_W           = 32;
    localparam int unsigned WEIGHT_FRAC_BITS = 17;
    localparam int unsigned WGT_W            = WEIGHT_FRAC_BITS + 1;

    localparam logic [DEG_W-1:0] MAX_DEGREE  = 12'd4095;
    localparam logic [DEG_W-1:0] START_RESET = 12'd0;
    localparam logic [DEG_W-1:0] STOP_RESET  = 12'd4095;

    // configuration register indexes
    localparam logic CFG_START = 1'b0;
    localparam logic CFG_STOP  = 1'b1;

    // phase divider
    localparam int unsigned PH_W    = 32;
    localparam int unsigned QUO_W   = PH_W + 1;
    localparam int unsigned DIV_BPS = 4;
    localparam int unsigned DIV_STAGES = (QUO_W + DIV_BPS - 1) / DIV_BPS;
    localparam int unsigned DIV_LAT = DIV_STAGES + 1;

    // cosine series, Q30
    localparam int unsigned TAYLOR_TERMS = 12;
    localparam int unsigned ANG_W   = 31;
    localparam int unsigned SQ_W    = 32;
    localparam int unsigned PROD_W  = ANG_W + SQ_W;
    localparam int unsigned Q_SH    = 30;
    localparam int unsigned X_W     = PROD_W - Q_SH;
    localparam int unsigned DVS_W   = 10;
    localparam int unsigned RECIP_SH = X_W;
    localparam int unsigned RECIP_W = RECIP_SH;
    localparam int unsigned COS_W   = 34;
    localparam int unsigned COS_LAT = 2 + 3 * TAYLOR_TERMS + 1;

    localparam logic [ANG_W-1:0] Q30_ONE     = 31'd1073741824;
    localparam logic [ANG_W-1:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic signed [63:0] C042_Q62 = 64'sd1936908127739502920;
    localparam logic signed [31:0] C008_Q32 = 32'sd343597384;

    localparam logic [DVS_W-1:0] DIV_EVEN [TAYLOR_TERMS] = '{
        10'd2,   10'd12,  10'd30,  10'd56,  10'd90,  10'd132,
        10'd182, 10'd240, 10'd306, 10'd380, 10'd462, 10'd552
    };
    localparam logic [DVS_W-1:0] DIV_ODD [TAYLOR_TERMS] = '{
        10'd6,   10'd20,  10'd42,  10'd72,  10'd110, 10'd156,
        10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600
    };

endpackage

// ===== sv/btdw_phase_div.sv =====
// ---------------------------------------------------------------------------
// Phase divider
// Pipelined restoring division giving the band phase round(k*2^32/(2d)).
// ---------------------------------------------------------------------------
module btdw_phase_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [btdw_pkg::DEG_W-1:0]       i_k,
    input  logic [btdw_pkg::DEG_W-1:0]       i_d,
    output logic [btdw_pkg::PH_W-1:0]        o_phase
);

    localparam int unsigned NS  = btdw_pkg::DIV_STAGES;
    localparam int unsigned BPS = btdw_pkg::DIV_BPS;
    localparam int unsigned DW  = btdw_pkg::DEG_W;
    localparam int unsigned QW  = btdw_pkg::QUO_W;

    logic [DW-1:0] r_rem [NS];
    logic [DW-1:0] r_d   [NS];
    logic [QW-1:0] r_quo [NS];
    logic [btdw_pkg::PH_W-1:0] r_ph;

    for (genvar s = 0; s < NS; s++) begin : g_st
        localparam int unsigned BASE = s * BPS;
        logic [DW-1:0] w_rem_in;
        logic [DW-1:0] w_d_in;
        logic [QW-1:0] w_quo_in;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (s == 0) begin : g_first
            assign w_rem_in = i_k;
            assign w_d_in   = i_d;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_d_in   = r_d[s-1];
            assign w_quo_in = r_quo[s-1];
        end

        always_comb begin
            logic [DW:0] v;
            v     = '0;
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            for (int j = 0; j < BPS; j++) begin
                if (BASE + j < QW) begin
                    if (BASE + j == 0) begin
                        v = {1'b0, n_rem};
                    end else begin
                        v = {n_rem, 1'b0};
                    end
                    if (v >= {1'b0, w_d_in}) begin
                        n_rem = DW'(v - {1'b0, w_d_in});
                        n_quo = {n_quo[QW-2:0], 1'b1};
                    end else begin
                        n_rem = v[DW-1:0];
                        n_quo = {n_quo[QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_d[s]   <= w_d_in;
                r_quo[s] <= n_quo;
            end
        end
    end

    logic [QW:0] w_rnd;
    assign w_rnd = {1'b0, r_quo[NS-1]} + {{QW{1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph <= w_rnd[btdw_pkg::PH_W:1];
        end
    end

    assign o_phase = r_ph;

endmodule

// ===== sv/btdw_cos.sv =====
// ---------------------------------------------------------------------------
// Cosine unit
// Quadrant folding and a pipelined 13-term Taylor series, Q30 result.
// ---------------------------------------------------------------------------
module btdw_cos (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [btdw_pkg::PH_W-1:0]              i_phase,
    output logic signed [btdw_pkg::COS_W-1:0]      o_cos
);

    localparam int unsigned NT  = btdw_pkg::TAYLOR_TERMS;
    localparam int unsigned AW  = btdw_pkg::ANG_W;
    localparam int unsigned SW  = btdw_pkg::SQ_W;
    localparam int unsigned PW  = btdw_pkg::PROD_W;
    localparam int unsigned XW  = btdw_pkg::X_W;
    localparam int unsigned MW  = btdw_pkg::RECIP_W;
    localparam int unsigned CW  = btdw_pkg::COS_W;
    localparam int unsigned DVW = btdw_pkg::DVS_W;
    localparam int unsigned QCW = XW + DVW;

    typedef struct packed {
        logic [SW-1:0]        a2;
        logic signed [CW-1:0] sum;
        logic                 odd;
        logic                 neg;
    } t_cos_car;

    logic [AW-1:0] r_ang;
    logic          r_odd0;
    logic          r_neg0;

    logic [AW-1:0] r_trm  [NT+1];
    t_cos_car      r_carc [NT+1];
    logic [PW-1:0] r_pa   [1:NT];
    t_cos_car      r_cara [1:NT];
    logic [XW-1:0] r_xb   [1:NT];
    logic [XW+MW-1:0] r_mb [1:NT];
    t_cos_car      r_carb [1:NT];
    logic signed [CW-1:0] r_cos;

    logic [60:0] w_angp;
    logic [2*AW-1:0] w_sqp;

    assign w_angp = 61'(i_phase[29:0]) * 61'(btdw_pkg::HALF_PI_Q30);
    assign w_sqp  = (2*AW)'(r_ang) * (2*AW)'(r_ang);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang  <= w_angp[60:30];
            r_odd0 <= i_phase[30];
            r_neg0 <= i_phase[31] ^ i_phase[30];
            r_trm[0]      <= r_odd0 ? r_ang : btdw_pkg::Q30_ONE;
            r_carc[0].a2  <= w_sqp[2*AW-1:btdw_pkg::Q_SH];
            r_carc[0].sum <= '0;
            r_carc[0].odd <= r_odd0;
            r_carc[0].neg <= r_neg0;
        end
    end

    for (genvar i = 1; i <= NT; i++) begin : g_term
        localparam logic [DVW-1:0] CE = btdw_pkg::DIV_EVEN[i-1];
        localparam logic [DVW-1:0] CO = btdw_pkg::DIV_ODD[i-1];
        localparam logic [MW-1:0] REC_E = MW'((66'd1 << btdw_pkg::RECIP_SH) / 66'(CE));
        localparam logic [MW-1:0] REC_O = MW'((66'd1 << btdw_pkg::RECIP_SH) / 66'(CO));
        localparam bit ADD_PREV = ((i - 1) % 2) == 0;

        logic signed [CW-1:0] w_prev;
        logic [XW-1:0]  w_x;
        logic [MW-1:0]  w_rec;
        logic [XW-1:0]  w_q;
        logic [DVW-1:0] w_c;
        logic [QCW-1:0] w_qc;
        logic [QCW-1:0] w_rm;
        logic [XW-1:0]  w_qf;
        t_cos_car       w_cara;

        assign w_prev = $signed({{(CW-AW){1'b0}}, r_trm[i-1]});
        assign w_x    = r_pa[i][PW-1:btdw_pkg::Q_SH];
        assign w_rec  = r_cara[i].odd ? REC_O : REC_E;
        assign w_q    = r_mb[i][XW+MW-1:btdw_pkg::RECIP_SH];
        assign w_c    = r_carb[i].odd ? CO : CE;
        assign w_qc   = QCW'(w_q) * QCW'(w_c);
        assign w_rm   = QCW'(r_xb[i]) - w_qc;
        assign w_qf   = (w_rm >= QCW'(w_c)) ? w_q + {{(XW-1){1'b0}}, 1'b1} : w_q;

        always_comb begin
            w_cara     = r_carc[i-1];
            w_cara.sum = ADD_PREV ? r_carc[i-1].sum + w_prev
                                  : r_carc[i-1].sum - w_prev;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa[i]   <= PW'(r_trm[i-1]) * PW'(r_carc[i-1].a2);
                r_cara[i] <= w_cara;
                r_xb[i]   <= w_x;
                r_mb[i]   <= (XW+MW)'(w_x) * (XW+MW)'(w_rec);
                r_carb[i] <= r_cara[i];
                r_trm[i]  <= w_qf[AW-1:0];
                r_carc[i] <= r_carb[i];
            end
        end
    end

    logic signed [CW-1:0] w_last;
    logic signed [CW-1:0] w_sum;

    assign w_last = $signed({{(CW-AW){1'b0}}, r_trm[NT]});
    assign w_sum  = ((NT % 2) == 0) ? r_carc[NT].sum + w_last : r_carc[NT].sum - w_last;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_carc[NT].neg ? -w_sum : w_sum;
        end
    end

    assign o_cos = r_cos;

endmodule

// ===== sv/blackman_taper_degree_weighting.sv =====
// ---------------------------------------------------------------------------
// Blackman taper degree weighting
// Scales each coefficient by a Blackman low-pass weight of its degree.
// ---------------------------------------------------------------------------
// One transaction is accepted every clock cycle unless the output stalls,
// and its result passes 54 register stages: one input register, a 10-stage
// phase divider resolving up to four quotient bits per stage, two 39-stage
// cosine series pipelines side by side, and four stages that form, clamp and
// apply the weight. A stall on the output holds the whole pipeline. The user
// writes configuration while the pipeline is empty; the block does not check.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module blackman_taper_degree_weighting (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [btdw_pkg::DEG_W-1:0]        i_cfg_wdata,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [47:0]                       i_s_tdata,   // degree_index, coefficient_in
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [btdw_pkg::COEF_W-1:0]       o_m_tdata,   // coefficient_out
    output logic [0:0]                        o_m_tuser    // config_error
);

    localparam int unsigned DW  = btdw_pkg::DEG_W;
    localparam int unsigned CFW = btdw_pkg::COEF_W;
    localparam int unsigned WB  = btdw_pkg::WEIGHT_FRAC_BITS;
    localparam int unsigned WGW = btdw_pkg::WGT_W;
    localparam int unsigned CW  = btdw_pkg::COS_W;
    localparam int unsigned P   = btdw_pkg::DIV_LAT + btdw_pkg::COS_LAT;
    localparam int unsigned LAST = P + 4;
    localparam int unsigned PRW = CFW + WGW;

    localparam logic signed [CW-1:0] COS_BOUND = CW'(64'sd1073742080);

    typedef enum logic [1:0] {
        KIND_TAPER,
        KIND_ONE,
        KIND_ZERO,
        KIND_ERR
    } t_kind;

    typedef struct packed {
        t_kind          kind;
        logic [CFW-1:0] mag;
        logic           neg;
    } t_side;

    logic [DW-1:0] r_start;
    logic [DW-1:0] r_stop;
    logic [LAST:0] r_vld;
    t_side         r_sb [P+3];
    logic [DW-1:0] r_k;
    logic [DW-1:0] r_d;

    logic w_en;
    assign w_en       = !r_vld[LAST] || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= btdw_pkg::START_RESET;
            r_stop  <= btdw_pkg::STOP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                btdw_pkg::CFG_START: r_start <= i_cfg_wdata;
                btdw_pkg::CFG_STOP:  r_stop  <= i_cfg_wdata;
            endcase
        end
    end

    logic [DW-1:0]  w_n;
    logic [CFW-1:0] w_coef;
    t_side          w_side;

    assign w_n    = i_s_tdata[DW-1:0];
    assign w_coef = i_s_tdata[DW+CFW-1:DW];

    always_comb begin
        w_side.neg = w_coef[CFW-1];
        w_side.mag = w_coef[CFW-1] ? (~w_coef + {{(CFW-1){1'b0}}, 1'b1}) : w_coef;
        if (r_start > r_stop) begin
            w_side.kind = KIND_ERR;
        end else if (w_n > btdw_pkg::MAX_DEGREE) begin
            w_side.kind = KIND_ZERO;
        end else if (w_n < r_start) begin
            w_side.kind = KIND_ONE;
        end else if (w_n > r_stop) begin
            w_side.kind = KIND_ZERO;
        end else if (r_start == r_stop) begin
            w_side.kind = KIND_ONE;
        end else begin
            w_side.kind = KIND_TAPER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k   <= w_n - r_start;
            r_d   <= r_stop - r_start;
            r_sb[0] <= w_side;
            for (int i = 1; i < P + 3; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    logic [btdw_pkg::PH_W-1:0] w_ph1;
    logic [btdw_pkg::PH_W-1:0] w_ph2;
    logic signed [CW-1:0]      w_cos1;
    logic signed [CW-1:0]      w_cos2;

    btdw_phase_div u_div (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_k     (r_k),
        .i_d     (r_d),
        .o_phase (w_ph1)
    );

    assign w_ph2 = {w_ph1[btdw_pkg::PH_W-2:0], 1'b0};

    btdw_cos u_cos1 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_ph1),
        .o_cos   (w_cos1)
    );

    btdw_cos u_cos2 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_ph2),
        .o_cos   (w_cos2)
    );

    logic signed [63:0] r_s1;
    logic signed [63:0] r_m2;
    logic [WGW-1:0]     r_w;
    logic [PRW-1:0]     r_prod;
    logic               r_neg3;
    logic               r_err3;
    logic [CFW-1:0]     r_out;
    logic               r_err4;

    logic signed [63:0] w_s;
    logic [62:0]        w_sc;
    logic [62:0]        w_wr;
    logic [WGW-1:0]     w_wsel;
    logic [PRW:0]       w_rnd;
    logic [CFW-1:0]     w_res;

    assign w_s  = r_s1 + r_m2;
    assign w_wr = w_sc + (63'd1 << (61 - WB));

    always_comb begin
        if (w_s < 64'sd0) begin
            w_sc = '0;
        end else if (w_s > (64'sd1 <<< 62)) begin
            w_sc = 63'd1 << 62;
        end else begin
            w_sc = w_s[62:0];
        end
    end

    always_comb begin
        case (r_sb[P+2].kind)
            KIND_TAPER: w_wsel = r_w;
            KIND_ONE:   w_wsel = WGW'(1) << WB;
            default:    w_wsel = '0;
        endcase
    end

    assign w_rnd = (PRW+1)'(r_prod) + ((PRW+1)'(1) << (WB - 1));
    assign w_res = w_rnd[WB+CFW-1:WB];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1   <= btdw_pkg::C042_Q62 + (64'(w_cos1) <<< 31);
            r_m2   <= 64'(w_cos2) * 64'(btdw_pkg::C008_Q32);
            r_w    <= w_wr[62 -: WGW];
            r_prod <= PRW'(r_sb[P+2].mag) * PRW'(w_wsel);
            r_neg3 <= r_sb[P+2].neg;
            r_err3 <= (r_sb[P+2].kind == KIND_ERR);
            r_out  <= r_neg3 ? -w_res : w_res;
            r_err4 <= r_err3;
        end
    end

    assign o_m_tvalid   = r_vld[LAST];
    assign o_m_tdata    = r_out;
    assign o_m_tuser[0] = r_err4;

    `BTDW_ASSERT(a_err_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0, "config error result not zero")
    `BTDW_ASSERT(a_cos_range, i_clk, i_rst_n, r_vld[P] |-> (w_cos1 <= COS_BOUND) && (w_cos1 >= -COS_BOUND), "cosine out of range")
    `BTDW_ASSERT(a_wgt_range, i_clk, i_rst_n, r_vld[P+2] |-> r_w <= (WGW'(1) << WB), "weight above one")
    `BTDW_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "pipeline not empty after reset")

endmodule

// ===== tb/blackman_taper_degree_weighting_tb.sv =====
// ---------------------------------------------------------------------------
// Blackman taper degree weighting testbench
// Streams degree/coefficient pairs through the taper under a range of band
// settings, with random gaps on both sides, and compares every returned
// transaction with a listed value or a bit-exact fixed-point Blackman model.
// ---------------------------------------------------------------------------
module blackman_taper_degree_weighting_tb;

    typedef struct {
        logic [31:0] coef;
        logic        err;
    } t_taper_res;

    typedef struct {
        logic [11:0] deg;
        logic [31:0] coef;
        logic [11:0] start;
        logic [11:0] stop;
        bit          typed;
        logic [31:0] exp_coef;
        logic        exp_err;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [11:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;   // degree_index [11:0], coefficient_in [43:12]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // coefficient_out
    logic [0:0]  o_m_tuser;        // config_error

    blackman_taper_degree_weighting dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [11:0] band_start = 12'd0;
    logic [11:0] band_stop  = 12'd4095;
    t_taper_res  pending_results[$];
    int          mismatches = 0;
    int          sent = 0;
    int          returned = 0;
    int          err_items = 0;
    int          settings = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;

    // cosine (odd = 0) or sine (odd = 1) series in Q30
    function automatic longint series_q30(longint unsigned a, bit odd);
        longint unsigned a2, term, k;
        longint acc;
        a2 = (a * a) >> 30;
        term = odd ? a : 64'd1073741824;
        k = odd ? 2 : 1;
        acc = longint'(term);
        for (int i = 1; i <= 12; i++) begin
            term = ((term * a2) >> 30) / (k * (k + 1));
            k += 2;
            if (i % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        return acc;
    endfunction

    function automatic longint cos_turn(logic [31:0] ph);
        longint unsigned ang;
        ang = ({34'd0, ph[29:0]} * 64'd1686629713) >> 30;
        case (ph[31:30])
            2'd0: return series_q30(ang, 1'b0);
            2'd1: return -series_q30(ang, 1'b1);
            2'd2: return -series_q30(ang, 1'b0);
            default: return series_q30(ang, 1'b1);
        endcase
    endfunction

    function automatic longint unsigned blackman_weight(logic [11:0] n);
        longint unsigned k, d, p1, s;
        longint acc;
        if (n < band_start) return 64'd1 << 17;
        if (n > band_stop) return 0;
        if (band_start == band_stop) return 64'd1 << 17;
        k = n - band_start;
        d = band_stop - band_start;
        p1 = (((k << 32) / d) + 1) >> 1;
        acc = 64'sd1936908127739502920 + cos_turn(p1[31:0]) * (64'sd1 <<< 31)
            + cos_turn({p1[30:0], 1'b0}) * 64'sd343597384;
        if (acc < 0) acc = 0;
        s = longint'(acc);
        if (s > (64'd1 << 62)) s = 64'd1 << 62;
        return (s + (64'd1 << 44)) >> 45;
    endfunction

    function automatic t_taper_res weighted_coef(logic [11:0] n, logic [31:0] c);
        t_taper_res r;
        longint unsigned mag, prod;
        r.err = 1'b0;
        if (band_start > band_stop) begin
            r.coef = '0;
            r.err = 1'b1;
            return r;
        end
        mag = c[31] ? {32'd0, -c} : {32'd0, c};
        prod = mag * blackman_weight(n);
        prod = (prod + (64'd1 << 16)) >> 17;
        if (c[31]) prod = -prod;
        r.coef = prod[31:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, returned);
    endtask

    task automatic drain();
        i_s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_band(logic [11:0] st, logic [11:0] sp);
        drain();
        write_reg(btdw_pkg::CFG_START, st);
        write_reg(btdw_pkg::CFG_STOP, sp);
        band_start = st;
        band_stop = sp;
        settings++;
    endtask

    task automatic send(logic [11:0] n, logic [31:0] c, bit typed = 0,
                        t_taper_res want = '{32'd0, 1'b0});
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata = {4'd0, c, n};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(typed ? want : weighted_coef(n, c));
        sent++;
        if (band_start > band_stop) err_items++;
        @(negedge i_clk);
    endtask

    // receiver
    initial begin
        int stall;
        t_taper_res want;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = no_gaps ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            if (pending_results.size() == 0) begin
                report("unexpected result", o_m_tdata, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.coef) report("coefficient_out", o_m_tdata, want.coef);
                if (o_m_tuser[0] !== want.err)
                    report("config_error", {31'd0, o_m_tuser}, {31'd0, want.err});
            end
            returned++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("status: fail");
            $finish;
        end
    end

    t_dir_row dir_rows[$];

    initial begin
        t_dir_row r;
        logic [11:0] st, sp, n;
        logic [31:0] c;
        int sel;
        dir_rows = '{
            '{12'd0,    32'h7fffffff, 12'd0,    12'd4095, 0, 32'd0, 1'b0},
            '{12'd4095, 32'h7fffffff, 12'd0,    12'd4095, 0, 32'd0, 1'b0},
            '{12'd2048, 32'h80000000, 12'd0,    12'd4095, 0, 32'd0, 1'b0},
            '{12'd1000, 32'hffffffff, 12'd0,    12'd4095, 0, 32'd0, 1'b0},
            '{12'd99,   32'h80000000, 12'd100,  12'd200,  1, 32'h80000000, 1'b0},
            '{12'd0,    32'h7fffffff, 12'd100,  12'd200,  1, 32'h7fffffff, 1'b0},
            '{12'd100,  32'h12345678, 12'd100,  12'd200,  1, 32'h12345678, 1'b0},
            '{12'd150,  32'h7fffffff, 12'd100,  12'd200,  0, 32'd0, 1'b0},
            '{12'd200,  32'h7fffffff, 12'd100,  12'd200,  0, 32'd0, 1'b0},
            '{12'd201,  32'h7fffffff, 12'd100,  12'd200,  1, 32'd0, 1'b0},
            '{12'd4095, 32'h80000000, 12'd100,  12'd200,  1, 32'd0, 1'b0},
            '{12'd300,  32'hdeadbeef, 12'd300,  12'd300,  1, 32'hdeadbeef, 1'b0},
            '{12'd301,  32'hdeadbeef, 12'd300,  12'd300,  1, 32'd0, 1'b0},
            '{12'd299,  32'h00000001, 12'd300,  12'd300,  1, 32'h00000001, 1'b0},
            '{12'd5,    32'h7fffffff, 12'd201,  12'd200,  1, 32'd0, 1'b1},
            '{12'd4095, 32'h80000000, 12'd201,  12'd200,  1, 32'd0, 1'b1},
            '{12'd4095, 32'h80000000, 12'd4095, 12'd0,    1, 32'd0, 1'b1},
            '{12'd4095, 32'h55555555, 12'd4095, 12'd4095, 1, 32'h55555555, 1'b0},
            '{12'd0,    32'haaaaaaaa, 12'd0,    12'd0,    1, 32'haaaaaaaa, 1'b0},
            '{12'd1,    32'h7fffffff, 12'd0,    12'd1,    0, 32'd0, 1'b0},
            '{12'd3,    32'hfffffffd, 12'd0,    12'd7,    0, 32'd0, 1'b0}
        };
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.start != band_start || r.stop != band_stop) set_band(r.start, r.stop);
            send(r.deg, r.coef, r.typed, '{r.exp_coef, r.exp_err});
        end

        for (int i = 0; i < 500; i++) begin
            if (i % 50 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
                sel = $urandom_range(0, 5);
                case (sel)
                    0: begin st = 12'd0; sp = 12'd4095; end
                    1: begin st = $urandom_range(0, 4095); sp = st; end
                    2: begin st = $urandom_range(1, 4095); sp = $urandom_range(0, st - 1); end
                    3: begin st = $urandom_range(0, 4000); sp = st + $urandom_range(1, 95); end
                    default: begin
                        st = $urandom_range(0, 4095);
                        sp = $urandom_range(st, 4095);
                    end
                endcase
                set_band(st, sp);
            end
            sel = $urandom_range(0, 9);
            if (sel < 7 && band_stop >= band_start)
                n = $urandom_range(band_start, band_stop);
            else
                n = $urandom_range(0, 4095);
            c = $urandom;
            if ($urandom_range(0, 15) == 0) c = $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
            send(n, c);
        end

        no_gaps = 1'b0;
        drain();
        $display("%0d transactions sent, %0d returned, over %0d band settings",
                 sent, returned, settings);
        $display("%0d transactions under an inverted band, %0d mismatches",
                 err_items, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/btdw_pkg.sv
sv/btdw_phase_div.sv
sv/btdw_cos.sv
sv/blackman_taper_degree_weighting.sv
tb/blackman_taper_degree_weighting_tb.sv
